@@ hdl/tar_pkg.sv @@
// ----------------------------------------------------------------------------
// tar_pkg
// Shared constants and types for the tensor axis reduce unit.
// ----------------------------------------------------------------------------
package tar_pkg;

  localparam int unsigned MaxInner = 1024;

  localparam int unsigned CellW  = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned OuterW = 16;
  localparam int unsigned AxisW  = 16;
  localparam int unsigned InnerW = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 16;

  localparam logic [ModeW-1:0] MODE_AVG   = 3'd0;
  localparam logic [ModeW-1:0] MODE_COUNT = 3'd1;
  localparam logic [ModeW-1:0] MODE_PROD  = 3'd2;
  localparam logic [ModeW-1:0] MODE_SUM   = 3'd3;
  localparam logic [ModeW-1:0] MODE_MAX   = 3'd4;
  localparam logic [ModeW-1:0] MODE_MIN   = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OUTER = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AXIS  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INNER = 3'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_UPD  = 4'b0100,
    S_DIV  = 4'b1000
  } state_e;

endpackage

@@ hdl/tar_ram.sv @@
// ----------------------------------------------------------------------------
// tar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tar_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/tensor_axis_reduce_unit.sv @@
// ----------------------------------------------------------------------------
// tensor_axis_reduce_unit
// Reduces a dense Q16.16 tensor along one axis with one accumulator per
// inner position.
// ----------------------------------------------------------------------------
// Cells enter in row-major order (outer, axis, inner). Each cell reads its
// accumulator from a single RAM, updates it and writes it back (accept, RAM
// read, update and write-back); the input stalls until the item is done. On
// the last axis index the result goes to an output register; the average
// adds a 32-step restoring divider. The next item is taken while a result
// still waits in the output register. Accumulators are not cleared: each is
// loaded on axis index zero before use.
module tensor_axis_reduce_unit #(
  parameter int unsigned MAX_INNER = tar_pkg::MaxInner,
  localparam int unsigned PosW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1,
  localparam int unsigned CntW = ($clog2(MAX_INNER + 1) > tar_pkg::InnerW)
                                 ? $clog2(MAX_INNER + 1) : tar_pkg::InnerW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tar_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tar_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [tar_pkg::CellW-1:0] cell_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [tar_pkg::CellW-1:0] reduced_value_o,
  output logic                          tensor_done_o
);

  localparam int unsigned W = tar_pkg::CellW;

  // configuration
  logic [tar_pkg::ModeW-1:0]  mode_q;
  logic [tar_pkg::OuterW-1:0] outer_cnt_q;
  logic [tar_pkg::AxisW-1:0]  axis_len_q;
  logic [tar_pkg::InnerW-1:0] inner_cnt_q;

  // positions
  logic [PosW-1:0]            inner_pos_q;
  logic [tar_pkg::AxisW-1:0]  axis_pos_q;
  logic [tar_pkg::OuterW-1:0] outer_pos_q;

  tar_pkg::state_e state_q, state_d;

  logic [PosW-1:0]  addr_q;
  logic [W-1:0]     cell_q;
  logic             first_q, last_q, done_q;
  logic [W-1:0]     acc_q;
  logic signed [2*W-1:0] prod_q;

  logic [16:0]      rem_q;
  logic [W-1:0]     quo_q;
  logic [5:0]       div_cnt_q;
  logic             div_neg_q;

  logic             out_valid_q, out_done_q;
  logic [W-1:0]     out_value_q;

  logic [tar_pkg::OuterW-1:0] eff_outer;
  logic [tar_pkg::AxisW-1:0]  eff_axis;
  logic [CntW-1:0]            eff_inner, inner_ext;
  logic                       in_accept, out_free;
  logic                       ip_last, ax_last, out_last;
  logic [PosW-1:0]            raddr;
  logic [W-1:0]               rdata;
  logic [W-1:0]               acc_new, avg_mag;
  logic [W:0]                 sum_w;
  logic [W-1:0]               sum_sat, prod_sat, count_val;
  logic                       ram_we, load_out;
  logic [W-1:0]               load_value;
  logic [16:0]                rem_sh;

  // effective geometry: zero acts as one, inner clipped to the RAM depth
  assign eff_outer = (outer_cnt_q == '0) ? tar_pkg::OuterW'(1) : outer_cnt_q;
  assign eff_axis  = (axis_len_q == '0) ? tar_pkg::AxisW'(1) : axis_len_q;
  assign inner_ext = CntW'(inner_cnt_q);
  always_comb begin
    if (inner_ext == '0) begin
      eff_inner = CntW'(1);
    end else if (inner_ext > CntW'(MAX_INNER)) begin
      eff_inner = CntW'(MAX_INNER);
    end else begin
      eff_inner = inner_ext;
    end
  end

  assign ip_last  = (CntW'(inner_pos_q) + CntW'(1)) == eff_inner;
  assign ax_last  = (axis_pos_q + tar_pkg::AxisW'(1)) == eff_axis;
  assign out_last = (outer_pos_q + tar_pkg::OuterW'(1)) == eff_outer;

  assign in_stall_o = (state_q != tar_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign raddr = in_accept ? inner_pos_q : addr_q;

  tar_ram #(
    .Width(W),
    .Depth(MAX_INNER)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(acc_new),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // update arithmetic
  assign sum_w   = {acc_q[W-1], acc_q} + {cell_q[W-1], cell_q};
  assign sum_sat = (sum_w[W] != sum_w[W-1])
                   ? (sum_w[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                   : sum_w[W-1:0];
  always_comb begin
    if (prod_q[2*W-1:W+15] == '0 || prod_q[2*W-1:W+15] == '1) begin
      prod_sat = prod_q[W+15:16];
    end else if (prod_q[2*W-1]) begin
      prod_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      prod_sat = {1'b0, {(W-1){1'b1}}};
    end
  end
  assign count_val = eff_axis[15] ? {1'b0, {(W-1){1'b1}}}
                                  : {1'b0, eff_axis[14:0], 16'b0};

  always_comb begin
    acc_new = acc_q;
    if (first_q) begin
      acc_new = cell_q;
    end else begin
      case (mode_q)
        tar_pkg::MODE_COUNT: acc_new = acc_q;
        tar_pkg::MODE_PROD:  acc_new = prod_sat;
        tar_pkg::MODE_MAX:   acc_new = ($signed(cell_q) > $signed(acc_q)) ? cell_q : acc_q;
        tar_pkg::MODE_MIN:   acc_new = ($signed(cell_q) < $signed(acc_q)) ? cell_q : acc_q;
        default:             acc_new = sum_sat;
      endcase
    end
  end

  assign avg_mag = acc_new[W-1] ? (~acc_new + W'(1)) : acc_new;
  assign rem_sh  = {rem_q[15:0], quo_q[W-1]};

  // control
  always_comb begin
    state_d    = state_q;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    load_value = acc_new;
    unique case (state_q)
      tar_pkg::S_IDLE: if (in_accept) state_d = tar_pkg::S_READ;
      tar_pkg::S_READ: state_d = tar_pkg::S_UPD;
      tar_pkg::S_UPD: begin
        ram_we = 1'b1;
        if (!last_q) begin
          state_d = tar_pkg::S_IDLE;
        end else if (mode_q == tar_pkg::MODE_AVG) begin
          state_d = tar_pkg::S_DIV;
        end else if (out_free) begin
          load_out   = 1'b1;
          load_value = (mode_q == tar_pkg::MODE_COUNT) ? count_val : acc_new;
          state_d    = tar_pkg::S_IDLE;
        end
      end
      tar_pkg::S_DIV: begin
        load_value = div_neg_q ? (~quo_q + W'(1)) : quo_q;
        if (div_cnt_q == '0 && out_free) begin
          load_out = 1'b1;
          state_d  = tar_pkg::S_IDLE;
        end
      end
      default: state_d = tar_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tar_pkg::S_IDLE;
      mode_q      <= tar_pkg::MODE_SUM;
      outer_cnt_q <= tar_pkg::OuterW'(1);
      axis_len_q  <= tar_pkg::AxisW'(1);
      inner_cnt_q <= tar_pkg::InnerW'(1);
      inner_pos_q <= '0;
      axis_pos_q  <= '0;
      outer_pos_q <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tar_pkg::REG_MODE:  mode_q      <= cfg_data_i[tar_pkg::ModeW-1:0];
          tar_pkg::REG_OUTER: outer_cnt_q <= cfg_data_i[tar_pkg::OuterW-1:0];
          tar_pkg::REG_AXIS:  axis_len_q  <= cfg_data_i[tar_pkg::AxisW-1:0];
          tar_pkg::REG_INNER: inner_cnt_q <= cfg_data_i[tar_pkg::InnerW-1:0];
          default: ;
        endcase
      end
      // restart the tensor on any geometry write
      if (cfg_we_i && (cfg_index_i == tar_pkg::REG_OUTER ||
                       cfg_index_i == tar_pkg::REG_AXIS ||
                       cfg_index_i == tar_pkg::REG_INNER)) begin
        inner_pos_q <= '0;
        axis_pos_q  <= '0;
        outer_pos_q <= '0;
      end else if (in_accept) begin
        if (ip_last) begin
          inner_pos_q <= '0;
          if (ax_last) begin
            axis_pos_q  <= '0;
            outer_pos_q <= out_last ? '0 : outer_pos_q + tar_pkg::OuterW'(1);
          end else begin
            axis_pos_q <= axis_pos_q + tar_pkg::AxisW'(1);
          end
        end else begin
          inner_pos_q <= inner_pos_q + PosW'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == tar_pkg::S_UPD && last_q && mode_q == tar_pkg::MODE_AVG) begin
        div_cnt_q <= 6'd32;
      end else if (state_q == tar_pkg::S_DIV && div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 6'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q  <= inner_pos_q;
      cell_q  <= cell_value_i;
      first_q <= (axis_pos_q == '0);
      last_q  <= ax_last;
      done_q  <= ip_last && out_last;
    end
    if (state_q == tar_pkg::S_READ) begin
      acc_q  <= rdata;
      prod_q <= $signed(rdata) * $signed(cell_q);
    end
    if (state_q == tar_pkg::S_UPD) begin
      rem_q     <= '0;
      quo_q     <= avg_mag;
      div_neg_q <= acc_new[W-1];
    end else if (state_q == tar_pkg::S_DIV && div_cnt_q != '0) begin
      // one quotient bit per cycle
      if (rem_sh >= {1'b0, eff_axis}) begin
        rem_q <= rem_sh - {1'b0, eff_axis};
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
    if (load_out) begin
      out_value_q <= load_value;
      out_done_q  <= done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reduced_value_o = out_value_q;
  assign tensor_done_o   = out_done_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("item accepted while the previous one is in flight");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == tar_pkg::S_UPD ||
                            $past(state_q) == tar_pkg::S_DIV))
    else $error("result loaded outside update or divide");

  a_inner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(inner_pos_q) < eff_inner)
    else $error("inner position out of range");
`endif

endmodule
